// ===== design/u8tl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8tl_pkg
// Shared types and constants of the UTF-8 text layout decoder: defaults,
// register indexes, controller states and the command/status structs.
// ----------------------------------------------------------------------------
package u8tl_pkg;

    // Parameter defaults
    localparam int LINE_ADVANCE_DEF = 18;
    localparam int COORD_BITS_DEF   = 16;

    // Field widths
    localparam int BYTE_W    = 8;
    localparam int CP_W      = 21;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X = 1'b0,
        CFG_ORIGIN_Y = 1'b1
    } t_cfg_reg;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_FLUSH,
        S_LEAD
    } t_state;

    // Datapath operations, one per cycle
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LEAD_IN,
        OP_CONT,
        OP_FLUSH_LOAD,
        OP_QMARK,
        OP_LEAD_HELD
    } t_op;

    typedef struct packed {
        logic take_in;
        t_op  op;
    } t_dp_cmd;

    typedef struct packed {
        logic in_valid;
        logic slot_free;
        logic in_seq;
        logic is_cont;
        logic completes;
        logic in_eot;
        logic flush_last;
        logic lead_after;
    } t_dp_status;

endpackage

// ===== design/u8tl_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8tl_in_if / u8tl_out_if
// Valid/ready channels: text bytes in, placed code points out.
// ----------------------------------------------------------------------------
interface u8tl_in_if;
    logic                         valid;
    logic                         ready;
    logic [u8tl_pkg::BYTE_W-1:0]  text_byte;
    logic                         end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface u8tl_out_if #(
    parameter int COORD_BITS = u8tl_pkg::COORD_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic [u8tl_pkg::CP_W-1:0]     code_point;
    logic signed [COORD_BITS-1:0]  pen_x;
    logic signed [COORD_BITS-1:0]  pen_y;
    logic                          run_last;
    logic                          text_done;

    modport source (output valid, output code_point, output pen_x, output pen_y,
                    output run_last, output text_done, input ready);
    modport sink   (input valid, input code_point, input pen_x, input pen_y,
                    input run_last, input text_done, output ready);
endinterface

// ===== design/u8tl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8tl_ctrl
// Controller: takes bytes in the idle state, steps through the '?' results
// of a broken sequence and then replays the offending byte as a lead unless it is a continuation.
// ----------------------------------------------------------------------------
module u8tl_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  u8tl_pkg::t_dp_status i_status,
    output u8tl_pkg::t_dp_cmd    o_cmd
);

    u8tl_pkg::t_state r_state;
    u8tl_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= u8tl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            u8tl_pkg::S_IDLE: begin
                if (i_status.in_valid && i_status.slot_free && i_status.in_seq &&
                    !(i_status.is_cont && (i_status.completes || !i_status.in_eot))) begin
                    n_state = u8tl_pkg::S_FLUSH;
                end
            end
            u8tl_pkg::S_FLUSH: begin
                if (i_status.slot_free && i_status.flush_last) begin
                    n_state = i_status.lead_after ? u8tl_pkg::S_LEAD : u8tl_pkg::S_IDLE;
                end
            end
            u8tl_pkg::S_LEAD: begin
                if (i_status.slot_free) begin
                    n_state = u8tl_pkg::S_IDLE;
                end
            end
            default: n_state = u8tl_pkg::S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd.take_in = 1'b0;
        o_cmd.op      = u8tl_pkg::OP_NONE;
        unique case (r_state)
            u8tl_pkg::S_IDLE: begin
                o_cmd.take_in = i_status.slot_free;
                if (i_status.in_valid && i_status.slot_free) begin
                    priority if (!i_status.in_seq) begin
                        o_cmd.op = u8tl_pkg::OP_LEAD_IN;
                    end else if (i_status.is_cont &&
                                 (i_status.completes || !i_status.in_eot)) begin
                        o_cmd.op = u8tl_pkg::OP_CONT;
                    end else begin
                        o_cmd.op = u8tl_pkg::OP_FLUSH_LOAD;
                    end
                end
            end
            u8tl_pkg::S_FLUSH: begin
                if (i_status.slot_free) begin
                    o_cmd.op = u8tl_pkg::OP_QMARK;
                end
            end
            u8tl_pkg::S_LEAD: begin
                if (i_status.slot_free) begin
                    o_cmd.op = u8tl_pkg::OP_LEAD_HELD;
                end
            end
            default: o_cmd.op = u8tl_pkg::OP_NONE;
        endcase
    end

    // A replay only ever follows a flush
    a_lead_after_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == u8tl_pkg::S_LEAD |-> $past(r_state) == u8tl_pkg::S_FLUSH ||
                                        $past(r_state) == u8tl_pkg::S_LEAD)
        else $error("lead replay entered without a flush");

    // Bytes are taken only in the idle state
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take_in |-> r_state == u8tl_pkg::S_IDLE)
        else $error("byte taken outside idle");

    // The flush leaves once its last '?' has gone out
    a_flush_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == u8tl_pkg::S_FLUSH && i_status.slot_free && i_status.flush_last
        |=> r_state != u8tl_pkg::S_FLUSH)
        else $error("flush did not end");

endmodule

// ===== design/u8tl_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8tl_datapath
// Sequence registers, pen position, origins and the result register.
// Executes one controller operation per cycle, at most one result each.
// ----------------------------------------------------------------------------
module u8tl_datapath #(
    parameter int LINE_ADVANCE = u8tl_pkg::LINE_ADVANCE_DEF,
    parameter int COORD_BITS   = u8tl_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    u8tl_in_if.sink                         i_byte_ch,
    u8tl_out_if.source                      o_glyph_ch,
    input  logic                            i_cfg_we,
    input  logic [u8tl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [u8tl_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  u8tl_pkg::t_dp_cmd               i_cmd,
    output u8tl_pkg::t_dp_status            o_status
);

    localparam int CW  = COORD_BITS;
    localparam int SW  = COORD_BITS + 9;
    localparam int EW  = ((COORD_BITS > u8tl_pkg::CFG_W) ? COORD_BITS : u8tl_pkg::CFG_W) + 1;
    localparam int BW  = u8tl_pkg::BYTE_W;
    localparam int CPW = u8tl_pkg::CP_W;

    localparam logic [BW-1:0]  NEWLINE    = 8'h0A;
    localparam logic [BW-1:0]  CONT_MASK  = 8'hC0;
    localparam logic [BW-1:0]  CONT_CODE  = 8'h80;
    localparam logic [BW-1:0]  LEAD2_MASK = 8'hE0;
    localparam logic [BW-1:0]  LEAD2_CODE = 8'hC0;
    localparam logic [BW-1:0]  LEAD3_MASK = 8'hF0;
    localparam logic [BW-1:0]  LEAD3_CODE = 8'hE0;
    localparam logic [BW-1:0]  LEAD4_MASK = 8'hF8;
    localparam logic [BW-1:0]  LEAD4_CODE = 8'hF0;
    localparam logic [BW-1:0]  PAY_CONT   = 8'h3F;
    localparam logic [BW-1:0]  PAY_LEAD2  = 8'h1F;
    localparam logic [BW-1:0]  PAY_LEAD3  = 8'h0F;
    localparam logic [BW-1:0]  PAY_LEAD4  = 8'h07;
    localparam logic [CPW-1:0] QMARK      = CPW'(63);
    localparam logic [CPW-1:0] ASCII_LIM  = CPW'(128);
    localparam logic [7:0]     ADV_NARROW = 8'd8;
    localparam logic [7:0]     ADV_WIDE   = 8'd16;
    localparam logic [7:0]     LINE_ADV   = 8'(LINE_ADVANCE);

    // Add a small positive step, sticking at the top of the coordinate range
    function automatic logic signed [CW-1:0] sat_add(input logic signed [CW-1:0] a,
                                                     input logic [7:0] inc);
        logic signed [SW-1:0] sum;
        logic signed [SW-1:0] hi;
        hi  = SW'(signed'({1'b0, {(CW-1){1'b1}}}));
        sum = SW'(a) + SW'(signed'({1'b0, inc}));
        if (sum > hi) begin
            return hi[CW-1:0];
        end
        return sum[CW-1:0];
    endfunction

    // Bring a 16-bit signed register value into the coordinate range
    function automatic logic signed [CW-1:0] sat_origin(input logic [u8tl_pkg::CFG_W-1:0] d);
        logic signed [EW-1:0] v;
        logic signed [EW-1:0] hi;
        logic signed [EW-1:0] lo;
        v  = EW'(signed'(d));
        hi = EW'(signed'({1'b0, {(CW-1){1'b1}}}));
        lo = ~hi;
        if (v > hi) begin
            return hi[CW-1:0];
        end
        if (v < lo) begin
            return lo[CW-1:0];
        end
        return v[CW-1:0];
    endfunction

    logic signed [CW-1:0] r_origin_x, n_origin_x;
    logic signed [CW-1:0] r_origin_y, n_origin_y;
    logic signed [CW-1:0] r_pen_col,  n_pen_col;
    logic signed [CW-1:0] r_pen_row,  n_pen_row;
    logic [2:0]           r_exp_len,  n_exp_len;
    logic [1:0]           r_held_cnt, n_held_cnt;
    logic [CPW-1:0]       r_acc,      n_acc;
    logic [BW-1:0]        r_byte,     n_byte;
    logic                 r_eot,      n_eot;
    logic [1:0]           r_flush_left, n_flush_left;
    logic                 r_lead_after, n_lead_after;
    logic                 r_lead_emits, n_lead_emits;
    logic                 r_o_valid,  n_o_valid;
    logic [CPW-1:0]       r_code,     n_code;
    logic signed [CW-1:0] r_px,       n_px;
    logic signed [CW-1:0] r_py,       n_py;
    logic                 r_last,     n_last;
    logic                 r_done,     n_done;

    logic           slot_free;
    logic [BW-1:0]  in_byte;
    logic           in_cont;
    logic           completes;
    logic [CPW-1:0] acc_shift;

    logic [BW-1:0]  lead_byte;
    logic           lead_eot;
    logic           lead_nl;
    logic           lead_multi;
    logic [2:0]     lead_len;
    logic [CPW-1:0] lead_bits;
    logic           lead_emits;
    logic [CPW-1:0] lead_cp;

    logic           do_emit;
    logic [CPW-1:0] emit_cp;
    logic           emit_last;
    logic           emit_done;
    logic           do_newline;
    logic           end_text;
    logic           q_last;

    // Handshake and status
    assign slot_free = !r_o_valid || o_glyph_ch.ready;
    assign i_byte_ch.ready = i_cmd.take_in;
    assign in_byte   = i_byte_ch.text_byte;
    assign in_cont   = (in_byte & CONT_MASK) == CONT_CODE;
    assign completes = ({1'b0, r_held_cnt} + 3'd1) == r_exp_len;
    assign acc_shift = {r_acc[CPW-7:0], in_byte[5:0] & PAY_CONT[5:0]};
    assign q_last    = (r_flush_left == 2'd1) && !(r_lead_after && r_lead_emits);

    assign o_status.in_valid   = i_byte_ch.valid;
    assign o_status.slot_free  = slot_free;
    assign o_status.in_seq     = r_exp_len != 3'd0;
    assign o_status.is_cont    = in_cont;
    assign o_status.completes  = completes;
    assign o_status.in_eot     = i_byte_ch.end_of_text;
    assign o_status.flush_last = r_flush_left == 2'd1;
    assign o_status.lead_after = r_lead_after;

    // Classify a lead byte: fresh input or the replayed one
    always_comb begin
        lead_byte  = (i_cmd.op == u8tl_pkg::OP_LEAD_HELD) ? r_byte : in_byte;
        lead_eot   = (i_cmd.op == u8tl_pkg::OP_LEAD_HELD) ? r_eot : i_byte_ch.end_of_text;
        lead_nl    = lead_byte == NEWLINE;
        lead_multi = 1'b1;
        lead_len   = 3'd0;
        lead_bits  = '0;
        priority if ((lead_byte & LEAD2_MASK) == LEAD2_CODE) begin
            lead_len  = 3'd2;
            lead_bits = CPW'(lead_byte & PAY_LEAD2);
        end else if ((lead_byte & LEAD3_MASK) == LEAD3_CODE) begin
            lead_len  = 3'd3;
            lead_bits = CPW'(lead_byte & PAY_LEAD3);
        end else if ((lead_byte & LEAD4_MASK) == LEAD4_CODE) begin
            lead_len  = 3'd4;
            lead_bits = CPW'(lead_byte & PAY_LEAD4);
        end else begin
            lead_multi = 1'b0;
        end
        lead_emits = !lead_nl && !(lead_multi && !lead_eot);
        lead_cp    = lead_byte[BW-1] ? QMARK : CPW'(lead_byte);
    end

    // Next values
    always_comb begin
        n_origin_x   = r_origin_x;
        n_origin_y   = r_origin_y;
        n_pen_col    = r_pen_col;
        n_pen_row    = r_pen_row;
        n_exp_len    = r_exp_len;
        n_held_cnt   = r_held_cnt;
        n_acc        = r_acc;
        n_byte       = r_byte;
        n_eot        = r_eot;
        n_flush_left = r_flush_left;
        n_lead_after = r_lead_after;
        n_lead_emits = r_lead_emits;
        n_o_valid    = r_o_valid && !o_glyph_ch.ready;
        n_code       = r_code;
        n_px         = r_px;
        n_py         = r_py;
        n_last       = r_last;
        n_done       = r_done;
        do_emit      = 1'b0;
        emit_cp      = QMARK;
        emit_last    = 1'b0;
        emit_done    = 1'b0;
        do_newline   = 1'b0;
        end_text     = 1'b0;

        unique case (i_cmd.op)
            u8tl_pkg::OP_LEAD_IN, u8tl_pkg::OP_LEAD_HELD: begin
                priority if (lead_nl) begin
                    do_newline = 1'b1;
                end else if (lead_multi && !lead_eot) begin
                    n_exp_len  = lead_len;
                    n_held_cnt = 2'd1;
                    n_acc      = lead_bits;
                end else begin
                    do_emit   = 1'b1;
                    emit_cp   = lead_cp;
                    emit_last = 1'b1;
                    emit_done = lead_eot;
                end
                end_text = lead_eot;
            end
            u8tl_pkg::OP_CONT: begin
                if (completes) begin
                    do_emit    = 1'b1;
                    emit_cp    = acc_shift;
                    emit_last  = 1'b1;
                    emit_done  = i_byte_ch.end_of_text;
                    end_text   = i_byte_ch.end_of_text;
                    n_exp_len  = 3'd0;
                    n_held_cnt = 2'd0;
                    n_acc      = '0;
                end else begin
                    n_held_cnt = r_held_cnt + 2'd1;
                    n_acc      = acc_shift;
                end
            end
            u8tl_pkg::OP_FLUSH_LOAD: begin
                // Latch the byte; a continuation here is taken with end of text
                n_byte       = in_byte;
                n_eot        = i_byte_ch.end_of_text;
                n_lead_after = !in_cont;
                n_lead_emits = lead_emits;
                n_flush_left = in_cont ? (r_held_cnt + 2'd1) : r_held_cnt;
                n_exp_len    = 3'd0;
                n_held_cnt   = 2'd0;
                n_acc        = '0;
            end
            u8tl_pkg::OP_QMARK: begin
                do_emit      = 1'b1;
                emit_cp      = QMARK;
                emit_last    = q_last;
                emit_done    = q_last && r_eot;
                n_flush_left = r_flush_left - 2'd1;
                end_text     = (r_flush_left == 2'd1) && !r_lead_after && r_eot;
            end
            default: begin
                do_emit = 1'b0;
            end
        endcase

        // Load the result register and advance the pen
        if (do_emit) begin
            n_o_valid = 1'b1;
            n_code    = emit_cp;
            n_px      = r_pen_col;
            n_py      = r_pen_row;
            n_last    = emit_last;
            n_done    = emit_done;
            n_pen_col = sat_add(r_pen_col, (emit_cp < ASCII_LIM) ? ADV_NARROW : ADV_WIDE);
        end
        if (do_newline) begin
            n_pen_col = r_origin_x;
            n_pen_row = sat_add(r_pen_row, LINE_ADV);
        end
        if (end_text) begin
            n_exp_len  = 3'd0;
            n_held_cnt = 2'd0;
            n_acc      = '0;
            n_pen_col  = r_origin_x;
            n_pen_row  = r_origin_y;
        end

        // Register writes move the pen at once
        if (i_cfg_we) begin
            unique case (u8tl_pkg::t_cfg_reg'(i_cfg_idx))
                u8tl_pkg::CFG_ORIGIN_X: begin
                    n_origin_x = sat_origin(i_cfg_wdata);
                    n_pen_col  = sat_origin(i_cfg_wdata);
                end
                u8tl_pkg::CFG_ORIGIN_Y: begin
                    n_origin_y = sat_origin(i_cfg_wdata);
                    n_pen_row  = sat_origin(i_cfg_wdata);
                end
                default: begin
                    n_origin_x = r_origin_x;
                end
            endcase
        end
    end

    // Control and pen registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x   <= '0;
            r_origin_y   <= '0;
            r_pen_col    <= '0;
            r_pen_row    <= '0;
            r_exp_len    <= 3'd0;
            r_held_cnt   <= 2'd0;
            r_acc        <= '0;
            r_flush_left <= 2'd0;
            r_lead_after <= 1'b0;
            r_lead_emits <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_origin_x   <= n_origin_x;
            r_origin_y   <= n_origin_y;
            r_pen_col    <= n_pen_col;
            r_pen_row    <= n_pen_row;
            r_exp_len    <= n_exp_len;
            r_held_cnt   <= n_held_cnt;
            r_acc        <= n_acc;
            r_flush_left <= n_flush_left;
            r_lead_after <= n_lead_after;
            r_lead_emits <= n_lead_emits;
            r_o_valid    <= n_o_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_eot  <= n_eot;
        r_code <= n_code;
        r_px   <= n_px;
        r_py   <= n_py;
        r_last <= n_last;
        r_done <= n_done;
    end

    assign o_glyph_ch.valid      = r_o_valid;
    assign o_glyph_ch.code_point = r_code;
    assign o_glyph_ch.pen_x      = r_px;
    assign o_glyph_ch.pen_y      = r_py;
    assign o_glyph_ch.run_last   = r_last;
    assign o_glyph_ch.text_done  = r_done;

    // A result is only loaded into a free slot
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_emit |-> slot_free)
        else $error("result register overwritten");

    // An open sequence holds fewer bytes than it expects
    a_seq_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_exp_len != 3'd0 |-> r_held_cnt != 2'd0 && {1'b0, r_held_cnt} < r_exp_len)
        else $error("sequence count out of shape");

    // Expected length is idle or a multi-byte lead length
    a_exp_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_exp_len == 3'd0 || r_exp_len == 3'd2 || r_exp_len == 3'd3 || r_exp_len == 3'd4)
        else $error("bad expected length");

    // A flush always has at least one '?' to give
    a_flush_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == u8tl_pkg::OP_FLUSH_LOAD |=> r_flush_left != 2'd0)
        else $error("empty flush");

endmodule

// ===== design/utf8_text_layout_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_text_layout_decoder
// Decodes a UTF-8 byte stream into code points with their pen positions.
// ----------------------------------------------------------------------------
// Usage:
//   i_byte_ch  : valid/ready channel of text bytes, each with end_of_text.
//   o_glyph_ch : valid/ready channel of results (code point, pen x/y,
//                run_last on the last result of a byte, text_done on the
//                last result of a text).
//   i_cfg_*    : write port for origin_x (index 0) and origin_y (index 1);
//                a write also moves the pen on that axis. Write when idle.
// Output: a result is loaded into the output register by the same clock
//   edge that transfers the byte that completes it.
// Throughput: one byte per cycle for well-formed text while results are
//   taken. A broken sequence is loaded, gives its '?' results, then
//   replays the offending byte as a lead if not a continuation; the
//   single result register and controller's flush/replay steps set this.
// Reset: pen and origins at zero, no open sequence, output empty.
// Stall: while a result waits untaken, no byte is transferred and the
//   flush holds; nothing is lost.
// ----------------------------------------------------------------------------
module utf8_text_layout_decoder #(
    parameter int LINE_ADVANCE = u8tl_pkg::LINE_ADVANCE_DEF,
    parameter int COORD_BITS   = u8tl_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    u8tl_in_if.sink                         i_byte_ch,
    u8tl_out_if.source                      o_glyph_ch,
    input  logic                            i_cfg_we,
    input  logic [u8tl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [u8tl_pkg::CFG_W-1:0]      i_cfg_wdata
);

    u8tl_pkg::t_dp_cmd    dp_cmd;
    u8tl_pkg::t_dp_status dp_status;

    // Sequencing
    u8tl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (dp_status),
        .o_cmd    (dp_cmd)
    );

    // Decode, pen and result register
    u8tl_datapath #(
        .LINE_ADVANCE (LINE_ADVANCE),
        .COORD_BITS   (COORD_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte_ch   (i_byte_ch),
        .o_glyph_ch  (o_glyph_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status)
    );

endmodule

// ===== tb/utf8_text_layout_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_text_layout_decoder_tb
// Self-checking bench for the UTF-8 text layout decoder. A queue of text
// bytes feeds a clocked driver. A clocked monitor checks every placed glyph
// against a local decoder and pen model, field by field. The run covers
// directed edge cases, random well-formed and broken texts, origin extremes,
// pen saturation, random idling on both sides and a long output stall.
// ----------------------------------------------------------------------------
module utf8_text_layout_decoder_tb;

    localparam int           CYCLE_LIMIT  = 300000;
    localparam int           LINE_STEP    = 18;
    localparam int           COORD_HI     = 32767;
    localparam int           COORD_LO     = -32768;
    localparam logic [20:0]  QMARK_CP     = 21'd63;
    localparam logic [7:0]   NEWLINE      = 8'h0A;
    localparam int           PHASE_BYTES  = 72;
    localparam int           NUM_PHASES   = 5;
    localparam int           HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [u8tl_pkg::BYTE_W-1:0] data;
        logic                        eot;
    } t_text_item;

    typedef struct packed {
        logic [u8tl_pkg::CP_W-1:0] cp;
        logic signed [15:0]        px;
        logic signed [15:0]        py;
        logic                      run_last;
        logic                      text_done;
    } t_glyph;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [u8tl_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [u8tl_pkg::CFG_W-1:0]     i_cfg_wdata;

    u8tl_in_if                     byte_ch ();
    u8tl_out_if #(.COORD_BITS(16)) glyph_ch ();

    utf8_text_layout_decoder #(
        .LINE_ADVANCE (LINE_STEP),
        .COORD_BITS   (16)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte_ch   (byte_ch),
        .o_glyph_ch  (glyph_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Clock: 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stimulus and checking state
    t_text_item text_q[$];
    t_glyph     glyph_q[$];
    t_glyph     step_q[$];
    t_text_item cur_item;
    bit         offering;
    bit         byte_taken;
    bit         rx_hold;
    int         tx_gap;
    int         rx_gap;
    int         tx_odds;
    int         rx_odds;
    int         mismatches;
    int         bytes_in;
    int         glyphs_out;
    int         cfg_writes;
    int         cycles;
    int         queued;

    // Decoder and pen model
    int          org_x, org_y;
    int          pen_c, pen_r;
    int          held_n, seq_len;
    logic [20:0] acc;

    function automatic int clamp_coord(input int v);
        if (v > COORD_HI) return COORD_HI;
        if (v < COORD_LO) return COORD_LO;
        return v;
    endfunction

    // Place one glyph at the pen and advance the pen
    function void place(input logic [20:0] cp);
        t_glyph g;
        g.cp        = cp;
        g.px        = pen_c[15:0];
        g.py        = pen_r[15:0];
        g.run_last  = 1'b0;
        g.text_done = 1'b0;
        step_q.push_back(g);
        pen_c = clamp_coord(pen_c + ((cp < 21'd128) ? 8 : 16));
    endfunction

    function void drop_seq();
        held_n  = 0;
        seq_len = 0;
        acc     = '0;
    endfunction

    // Open lead and each held continuation become '?'
    function void flush_open();
        place(QMARK_CP);
        for (int k = 1; k < held_n; k++) place(QMARK_CP);
        drop_seq();
    endfunction

    function void start_lead(input logic [7:0] b, input bit eot);
        int          len;
        logic [20:0] bits;
        if (b == NEWLINE) begin
            pen_c = org_x;
            pen_r = clamp_coord(pen_r + LINE_STEP);
            return;
        end
        if (b[7] == 1'b0) begin
            place({13'd0, b});
            return;
        end
        if ((b & 8'hE0) == 8'hC0) begin
            len  = 2;
            bits = {16'd0, b[4:0]};
        end else if ((b & 8'hF0) == 8'hE0) begin
            len  = 3;
            bits = {17'd0, b[3:0]};
        end else if ((b & 8'hF8) == 8'hF0) begin
            len  = 4;
            bits = {18'd0, b[2:0]};
        end else begin
            place(QMARK_CP);
            return;
        end
        if (eot) begin
            place(QMARK_CP);
            return;
        end
        held_n  = 1;
        seq_len = len;
        acc     = bits;
    endfunction

    // Work out the glyphs that one transferred byte causes
    function void predict_byte(input logic [7:0] b, input bit eot);
        step_q.delete();
        if (seq_len != 0 && held_n >= 1 && held_n < 4) begin
            if ((b & 8'hC0) == 8'h80) begin
                acc = {acc[14:0], b[5:0]};
                held_n++;
                if (held_n >= seq_len) begin
                    place(acc);
                    drop_seq();
                end else if (eot) begin
                    flush_open();
                end
            end else begin
                flush_open();
                start_lead(b, eot);
            end
        end else begin
            drop_seq();
            start_lead(b, eot);
        end
        if (step_q.size() > 0) begin
            step_q[step_q.size()-1].run_last = 1'b1;
            if (eot) step_q[step_q.size()-1].text_done = 1'b1;
        end
        foreach (step_q[k]) glyph_q.push_back(step_q[k]);
        if (eot) begin
            drop_seq();
            pen_c = org_x;
            pen_r = org_y;
        end
    endfunction

    // Queue helpers
    function void push_byte(input logic [7:0] b, input bit eot);
        t_text_item t;
        t.data = b;
        t.eot  = eot;
        text_q.push_back(t);
        queued++;
    endfunction

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    function void push_lead(input int len);
        case (len)
            2: push_byte(8'hC0 | 8'($urandom_range(0, 31)), 1'b0);
            3: push_byte(8'hE0 | 8'($urandom_range(0, 15)), 1'b0);
            default: push_byte(8'hF0 | 8'($urandom_range(0, 7)), 1'b0);
        endcase
    endfunction

    // One random text: mostly well-formed characters, some noise, eot last
    function void add_text();
        int nchars, kind, len, conts;
        nchars = $urandom_range(1, 10);
        for (int c = 0; c < nchars; c++) begin
            kind = $urandom_range(0, 99);
            if (kind < 38) begin
                push_byte(8'($urandom_range(1, 127)), 1'b0);
            end else if (kind < 46) begin
                push_byte(NEWLINE, 1'b0);
            end else if (kind < 84) begin
                len = $urandom_range(2, 4);
                push_lead(len);
                for (int k = 1; k < len; k++) push_byte(cont_byte(), 1'b0);
            end else if (kind < 91) begin
                if ($urandom_range(0, 1) == 0) push_byte(cont_byte(), 1'b0);
                else push_byte(8'hF8 | 8'($urandom_range(0, 7)), 1'b0);
            end else begin
                // truncated sequence; the next byte is the offender
                len   = $urandom_range(2, 4);
                conts = $urandom_range(0, len - 2);
                push_lead(len);
                for (int k = 0; k < conts; k++) push_byte(cont_byte(), 1'b0);
            end
        end
        text_q[text_q.size()-1].eot = 1'b1;
    endfunction

    // Write one origin register; the pen follows at once
    task automatic cfg_write(input u8tl_pkg::t_cfg_reg idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == u8tl_pkg::CFG_ORIGIN_X) begin
            org_x = int'($signed(val));
            pen_c = org_x;
        end else begin
            org_y = int'($signed(val));
            pen_r = org_y;
        end
        cfg_writes++;
    endtask

    // Hold until every byte is taken and every glyph has come, then settle
    task automatic wait_drained();
        while (text_q.size() != 0 || offering || glyph_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Byte driver: offer the next queued byte, with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            byte_ch.valid <= 1'b0;
        end else begin
            if (byte_taken) begin
                offering   = 1'b0;
                byte_taken = 1'b0;
            end
            if (!offering) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (text_q.size() != 0 && tx_odds != 0 &&
                             $urandom_range(0, tx_odds) == 0) begin
                    tx_gap = $urandom_range(0, 13);
                end else if (text_q.size() != 0) begin
                    cur_item = text_q.pop_front();
                    offering = 1'b1;
                end
            end
            byte_ch.valid <= offering;
            if (offering) begin
                byte_ch.text_byte   <= cur_item.data;
                byte_ch.end_of_text <= cur_item.eot;
            end
        end
    end

    // Byte transfer: update the model
    always @(posedge i_clk) begin
        if (i_rst_n && byte_ch.valid && byte_ch.ready) begin
            predict_byte(byte_ch.text_byte, byte_ch.end_of_text);
            byte_taken = 1'b1;
            bytes_in++;
        end
    end

    // Glyph receiver: random stall bursts, plus the long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n || rx_hold) begin
            glyph_ch.ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            glyph_ch.ready <= 1'b0;
        end else if (rx_odds != 0 && $urandom_range(0, rx_odds) == 0) begin
            rx_gap = $urandom_range(0, 13);
            glyph_ch.ready <= 1'b0;
        end else begin
            glyph_ch.ready <= 1'b1;
        end
    end

    // Glyph monitor: compare against the oldest expectation
    always @(posedge i_clk) begin
        t_glyph got, want;
        if (i_rst_n && glyph_ch.valid && glyph_ch.ready) begin
            got.cp        = glyph_ch.code_point;
            got.px        = glyph_ch.pen_x;
            got.py        = glyph_ch.pen_y;
            got.run_last  = glyph_ch.run_last;
            got.text_done = glyph_ch.text_done;
            glyphs_out++;
            if (glyph_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: unexpected glyph cp=%0d x=%0d y=%0d", got.cp,
                             got.px, got.py);
            end else begin
                want = glyph_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at glyph %0d: exp cp=%0d x=%0d y=%0d last=%0b done=%0b",
                                 glyphs_out, want.cp, want.px, want.py, want.run_last,
                                 want.text_done);
                        $display("    got cp=%0d x=%0d y=%0d last=%0b done=%0b",
                                 got.cp, got.px, got.py, got.run_last, got.text_done);
                    end
                end
            end
        end
    end

    // Long output stall once the run is under way; the input backs up
    initial begin
        rx_hold = 1'b0;
        wait (bytes_in >= 120);
        @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d glyphs outstanding", cycles,
                     glyph_q.size());
            $display("FAIL");
            $finish;
        end
    end

    // Main sequence
    initial begin
        int ox_set [NUM_PHASES];
        int oy_set [NUM_PHASES];
        ox_set = '{-32768, 32767, 32600, 0, 0};
        oy_set = '{-32768, 32767, 32700, 0, 0};

        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = u8tl_pkg::CFG_ORIGIN_X;
        i_cfg_wdata          = '0;
        byte_ch.valid        = 1'b0;
        byte_ch.text_byte    = '0;
        byte_ch.end_of_text  = 1'b0;
        glyph_ch.ready       = 1'b0;
        offering   = 1'b0;
        byte_taken = 1'b0;
        tx_gap = 0;
        rx_gap = 0;
        tx_odds = 6;
        rx_odds = 6;
        mismatches = 0;
        bytes_in = 0;
        glyphs_out = 0;
        cfg_writes = 0;
        cycles = 0;
        queued = 0;
        org_x = 0;
        org_y = 0;
        pen_c = 0;
        pen_r = 0;
        drop_seq();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, each sequence length, invalid leads, broken
        // sequences, newline as offender, end of text in mid-sequence
        cfg_write(u8tl_pkg::CFG_ORIGIN_X, 16'd40);
        cfg_write(u8tl_pkg::CFG_ORIGIN_Y, 16'd100);
        push_byte(8'h41, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(NEWLINE, 1'b0);
        push_byte(8'hC3, 1'b0);
        push_byte(8'hA9, 1'b0);
        push_byte(8'hE2, 1'b0);
        push_byte(8'h82, 1'b0);
        push_byte(8'hAC, 1'b0);
        push_byte(8'hF0, 1'b0);
        push_byte(8'h9F, 1'b0);
        push_byte(8'h98, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hF8, 1'b0);
        push_byte(8'hE2, 1'b0);
        push_byte(8'h82, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(8'hF4, 1'b0);
        push_byte(NEWLINE, 1'b0);
        push_byte(8'hE2, 1'b0);
        push_byte(8'h82, 1'b1);
        push_byte(8'hC3, 1'b1);
        push_byte(NEWLINE, 1'b1);
        wait_drained();

        // Random texts over several origin settings
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == 3) begin
                cfg_write(u8tl_pkg::CFG_ORIGIN_X, 16'($urandom_range(0, 65535)));
                cfg_write(u8tl_pkg::CFG_ORIGIN_Y, 16'($urandom_range(0, 65535)));
            end else begin
                cfg_write(u8tl_pkg::CFG_ORIGIN_X, 16'(ox_set[p]));
                cfg_write(u8tl_pkg::CFG_ORIGIN_Y, 16'(oy_set[p]));
            end
            if (p == NUM_PHASES - 1) begin
                tx_odds = 0;
                rx_odds = 0;
            end else begin
                tx_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 10);
                rx_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 10);
            end
            queued = 0;
            while (queued < PHASE_BYTES) add_text();
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        $display("run covered %0d text bytes and %0d glyphs over %0d origin writes,",
                 bytes_in, glyphs_out, cfg_writes);
        $display("with range extremes, pen saturation, broken sequences and a long stall");
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAIL");
        end
        $finish;
    end

endmodule
